>>> src/rwla_pkg.sv
// Shared types, codes and helpers for the reader-writer lock arbiter.
// Used by rwla_ctrl, rwla_datapath and reader_writer_lock_arbiter_top; no dependencies.
`timescale 1ns / 1ps

package rwla_pkg;

    // field widths
    localparam int OPCODE_W   = 4;
    localparam int ID_W       = 4;
    localparam int NUM_IDS    = 1 << ID_W;
    localparam int CNT_W      = 5;
    localparam int STATUS_W   = 3;
    localparam int POLICY_W   = 3;
    localparam int LIMIT_W    = 5;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;

    // default depth of the round-robin order list
    localparam int DEF_MAX_REQUESTERS = 16;

    // request opcodes
    localparam logic [OPCODE_W-1:0] OP_EXCL_ACQ   = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_EXCL_REL   = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_READ_LOCK  = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_READ_TRY   = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_READ_REL   = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_WRITE_LOCK = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_WRITE_TRY  = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_WRITE_REL  = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_REGISTER   = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_UNREGISTER = 4'd9;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REFUSED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_HOLDS     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_LIST_FULL = 3'd4;

    // grant policies
    localparam logic [POLICY_W-1:0] POL_EXCLUSIVE = 3'd0;
    localparam logic [POLICY_W-1:0] POL_NONE      = 3'd1;
    localparam logic [POLICY_W-1:0] POL_RR        = 3'd2;
    localparam logic [POLICY_W-1:0] POL_READER    = 3'd3;
    localparam logic [POLICY_W-1:0] POL_WRITER    = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY       = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_READER_LIMIT = 1'd1;

    // request and result items
    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [ID_W-1:0]     requester_id;
    } req_item_t;

    typedef struct packed {
        logic                granted;
        logic [STATUS_W-1:0] status;
        logic [CNT_W-1:0]    readers_held;
        logic [CNT_W-1:0]    writers_held;
        logic [CNT_W-1:0]    readers_waiting;
        logic                exclusive_held;
    } rsp_item_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN_RD,
        S_SCAN_WR,
        S_UNREG_END
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic exec;
        logic scan_start;
        logic scan_sel;
        logic scan_write;
        logic unreg_finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_unreg;
        logic scan_more;
        logic out_free;
    } ctrl_sts_t;

    // saturating increment of a count
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
        return r;
    endfunction

endpackage

>>> src/rwla_ctrl.sv
// Sequencing state machine of the reader-writer lock arbiter.
// Depends on rwla_pkg; drives rwla_datapath through command and status structs.
`timescale 1ns / 1ps

module rwla_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  rwla_pkg::ctrl_sts_t sts,
    output rwla_pkg::ctrl_cmd_t cmd
);

    rwla_pkg::ctrl_state_t state_reg;
    rwla_pkg::ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rwla_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rwla_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = rwla_pkg::S_EXEC;
                end
            end
            rwla_pkg::S_EXEC:
            begin
                if (sts.is_unreg)
                begin
                    state_next = rwla_pkg::S_SCAN_RD;
                end
                else if (sts.out_free)
                begin
                    state_next = rwla_pkg::S_IDLE;
                end
            end
            rwla_pkg::S_SCAN_RD:
            begin
                if (sts.scan_more)
                begin
                    state_next = rwla_pkg::S_SCAN_WR;
                end
                else
                begin
                    state_next = rwla_pkg::S_UNREG_END;
                end
            end
            rwla_pkg::S_SCAN_WR:
            begin
                state_next = rwla_pkg::S_SCAN_RD;
            end
            rwla_pkg::S_UNREG_END:
            begin
                if (sts.out_free)
                begin
                    state_next = rwla_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = rwla_pkg::S_IDLE;
            end
        endcase
    end

    // commands
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            rwla_pkg::S_IDLE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            rwla_pkg::S_EXEC:
            begin
                cmd.scan_start = sts.is_unreg;
                cmd.exec       = !sts.is_unreg && sts.out_free;
            end
            rwla_pkg::S_SCAN_RD:
            begin
                cmd.scan_sel = 1'b1;
            end
            rwla_pkg::S_SCAN_WR:
            begin
                cmd.scan_write = 1'b1;
            end
            rwla_pkg::S_UNREG_END:
            begin
                cmd.unreg_finish = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> src/rwla_datapath.sv
// Lock state, order-list memory, grant decisions and result register.
// Depends on rwla_pkg; commanded by rwla_ctrl.
`timescale 1ns / 1ps

module rwla_datapath #(
    parameter int MAX_REQUESTERS = rwla_pkg::DEF_MAX_REQUESTERS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rwla_pkg::req_item_t                   req,
    input  logic                                  cfg_we,
    input  logic [rwla_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rwla_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  rwla_pkg::ctrl_cmd_t                   cmd,
    output rwla_pkg::ctrl_sts_t                   sts,
    output logic                                  rsp_valid,
    input  logic                                  rsp_ready,
    output rwla_pkg::rsp_item_t                   rsp
);

    localparam int LEN_W = $clog2(MAX_REQUESTERS + 1);
    localparam int IDX_W = (MAX_REQUESTERS > 1) ? $clog2(MAX_REQUESTERS) : 1;
    localparam int CNT_W = rwla_pkg::CNT_W;
    localparam int NIDS  = rwla_pkg::NUM_IDS;

    // configuration
    logic [rwla_pkg::POLICY_W-1:0] policy_reg;
    logic [rwla_pkg::LIMIT_W-1:0]  limit_reg;

    // captured request
    logic [rwla_pkg::OPCODE_W-1:0] op_reg;
    logic [rwla_pkg::ID_W-1:0]     id_reg;

    // lock state
    logic             excl_reg,  excl_next;
    logic [CNT_W-1:0] rcnt_reg,  rcnt_next;
    logic [CNT_W-1:0] wcnt_reg,  wcnt_next;
    logic [CNT_W-1:0] wait_reg,  wait_next;
    logic [NIDS-1:0]  wbits_reg, wbits_next;
    logic [NIDS-1:0]  hbits_reg, hbits_next;
    logic [LEN_W-1:0] len_reg,   len_next;
    logic [IDX_W-1:0] turn_reg,  turn_next;

    // compaction pointers
    logic [LEN_W-1:0] rptr_reg;
    logic [LEN_W-1:0] wptr_reg;

    // order list memory
    logic [rwla_pkg::ID_W-1:0] order_mem [MAX_REQUESTERS];
    logic [rwla_pkg::ID_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]          rd_addr;
    logic                      wr_en;
    logic [IDX_W-1:0]          wr_addr;
    logic [rwla_pkg::ID_W-1:0] wr_data;

    // result register
    rwla_pkg::rsp_item_t out_reg;
    logic                out_valid_reg;

    // decision signals
    logic [NIDS-1:0]           id_bit;
    logic                      holds;
    logic                      is_acquire;
    logic                      is_turn;
    logic                      limit_hit;
    logic                      idle;
    logic                      read_ok;
    logic                      write_ok;
    logic [LEN_W-1:0]          turn_inc;
    logic [IDX_W-1:0]          turn_adv;
    logic [IDX_W-1:0]          turn_dec;
    logic                      list_full;
    logic [CNT_W-1:0]          wait_tmp;
    logic                      granted;
    logic [rwla_pkg::STATUS_W-1:0] status;
    logic                      load_out;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= rwla_pkg::POL_NONE;
            limit_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rwla_pkg::CFG_POLICY:       policy_reg <= cfg_data[rwla_pkg::POLICY_W-1:0];
                rwla_pkg::CFG_READER_LIMIT: limit_reg  <= cfg_data[rwla_pkg::LIMIT_W-1:0];
                default:                    limit_reg  <= limit_reg;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg <= req.opcode;
            id_reg <= req.requester_id;
        end
    end

    // order list: one write port, one registered read port
    assign rd_addr = cmd.scan_sel ? rptr_reg[IDX_W-1:0] : turn_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            order_mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= order_mem[rd_addr];
    end

    assign list_full = (len_reg >= LEN_W'(MAX_REQUESTERS));
    assign wr_en     = (cmd.exec && (op_reg == rwla_pkg::OP_REGISTER) && !list_full)
                    || (cmd.scan_write && (rd_data_reg != id_reg));
    assign wr_addr   = cmd.scan_write ? wptr_reg[IDX_W-1:0] : len_reg[IDX_W-1:0];
    assign wr_data   = cmd.scan_write ? rd_data_reg : id_reg;

    // turn arithmetic
    assign turn_inc = LEN_W'(turn_reg) + LEN_W'(1);
    assign turn_adv = (turn_inc >= len_reg) ? '0 : turn_inc[IDX_W-1:0];
    assign turn_dec = (turn_reg != '0) ? turn_reg - IDX_W'(1) : turn_reg;
    assign is_turn  = (len_reg != '0) && (LEN_W'(turn_reg) < len_reg) && (rd_data_reg == id_reg);

    // grant conditions
    always_comb
    begin
        id_bit         = '0;
        id_bit[id_reg] = 1'b1;
    end

    assign holds      = (hbits_reg & id_bit) != '0;
    assign is_acquire = (op_reg == rwla_pkg::OP_EXCL_ACQ) || (op_reg == rwla_pkg::OP_READ_LOCK)
                     || (op_reg == rwla_pkg::OP_READ_TRY) || (op_reg == rwla_pkg::OP_WRITE_LOCK)
                     || (op_reg == rwla_pkg::OP_WRITE_TRY);
    assign limit_hit  = (limit_reg != '0) && (rcnt_reg >= limit_reg);
    assign idle       = (rcnt_reg == '0) && (wcnt_reg == '0);

    always_comb
    begin
        case (policy_reg)
            rwla_pkg::POL_EXCLUSIVE: read_ok = !limit_hit && idle;
            rwla_pkg::POL_RR:        read_ok = !limit_hit && idle && is_turn;
            rwla_pkg::POL_READER:    read_ok = !limit_hit;
            rwla_pkg::POL_WRITER:    read_ok = idle;
            default:                 read_ok = (wcnt_reg == '0) && !limit_hit;
        endcase
        case (policy_reg)
            rwla_pkg::POL_RR:        write_ok = idle && is_turn;
            rwla_pkg::POL_READER:    write_ok = (rcnt_reg == '0) && (wait_reg == '0);
            rwla_pkg::POL_WRITER:    write_ok = 1'b1;
            default:                 write_ok = idle;
        endcase
        if (excl_reg)
        begin
            read_ok  = 1'b0;
            write_ok = 1'b0;
        end
    end

    // next lock state for one request
    always_comb
    begin
        excl_next  = excl_reg;
        rcnt_next  = rcnt_reg;
        wcnt_next  = wcnt_reg;
        wait_next  = wait_reg;
        wbits_next = wbits_reg;
        hbits_next = hbits_reg;
        len_next   = len_reg;
        turn_next  = turn_reg;
        granted    = 1'b0;
        status     = rwla_pkg::STAT_DONE;
        wait_tmp   = wait_reg;
        if (is_acquire && holds)
        begin
            status = rwla_pkg::STAT_HOLDS;
        end
        else
        begin
            case (op_reg)
                rwla_pkg::OP_EXCL_ACQ:
                begin
                    if (!excl_reg && idle)
                    begin
                        excl_next  = 1'b1;
                        hbits_next = hbits_reg | id_bit;
                        granted    = 1'b1;
                    end
                    else
                    begin
                        status = rwla_pkg::STAT_REFUSED;
                    end
                end
                rwla_pkg::OP_READ_LOCK:
                begin
                    // a blocking read marks its requester as waiting first
                    if ((wbits_reg & id_bit) == '0)
                    begin
                        wait_tmp = rwla_pkg::sat_inc(wait_reg);
                    end
                    if (read_ok)
                    begin
                        rcnt_next  = rwla_pkg::sat_inc(rcnt_reg);
                        hbits_next = hbits_reg | id_bit;
                        granted    = 1'b1;
                        wbits_next = wbits_reg & ~id_bit;
                        wait_next  = (wait_tmp != '0) ? wait_tmp - CNT_W'(1) : wait_tmp;
                        turn_next  = turn_adv;
                    end
                    else
                    begin
                        wbits_next = wbits_reg | id_bit;
                        wait_next  = wait_tmp;
                        status     = rwla_pkg::STAT_REFUSED;
                    end
                end
                rwla_pkg::OP_READ_TRY:
                begin
                    if (read_ok)
                    begin
                        rcnt_next  = rwla_pkg::sat_inc(rcnt_reg);
                        hbits_next = hbits_reg | id_bit;
                        granted    = 1'b1;
                    end
                    else
                    begin
                        status = rwla_pkg::STAT_REFUSED;
                    end
                end
                rwla_pkg::OP_WRITE_LOCK, rwla_pkg::OP_WRITE_TRY:
                begin
                    if (write_ok)
                    begin
                        wcnt_next  = rwla_pkg::sat_inc(wcnt_reg);
                        hbits_next = hbits_reg | id_bit;
                        granted    = 1'b1;
                        if (op_reg == rwla_pkg::OP_WRITE_LOCK)
                        begin
                            turn_next = turn_adv;
                        end
                    end
                    else
                    begin
                        status = rwla_pkg::STAT_REFUSED;
                    end
                end
                rwla_pkg::OP_EXCL_REL:
                begin
                    if (!excl_reg)
                    begin
                        status = rwla_pkg::STAT_UNDERFLOW;
                    end
                    excl_next  = 1'b0;
                    hbits_next = hbits_reg & ~id_bit;
                end
                rwla_pkg::OP_READ_REL:
                begin
                    if (rcnt_reg == '0)
                    begin
                        status = rwla_pkg::STAT_UNDERFLOW;
                    end
                    else
                    begin
                        rcnt_next = rcnt_reg - CNT_W'(1);
                    end
                    hbits_next = hbits_reg & ~id_bit;
                end
                rwla_pkg::OP_WRITE_REL:
                begin
                    if (wcnt_reg == '0)
                    begin
                        status = rwla_pkg::STAT_UNDERFLOW;
                    end
                    else
                    begin
                        wcnt_next = wcnt_reg - CNT_W'(1);
                    end
                    hbits_next = hbits_reg & ~id_bit;
                end
                rwla_pkg::OP_REGISTER:
                begin
                    if (list_full)
                    begin
                        status = rwla_pkg::STAT_LIST_FULL;
                    end
                    else
                    begin
                        len_next = len_reg + LEN_W'(1);
                    end
                end
                default:
                begin
                    status = rwla_pkg::STAT_DONE;
                end
            endcase
        end
    end

    // lock state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            excl_reg  <= 1'b0;
            rcnt_reg  <= '0;
            wcnt_reg  <= '0;
            wait_reg  <= '0;
            wbits_reg <= '0;
            hbits_reg <= '0;
            len_reg   <= '0;
            turn_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            excl_reg  <= excl_next;
            rcnt_reg  <= rcnt_next;
            wcnt_reg  <= wcnt_next;
            wait_reg  <= wait_next;
            wbits_reg <= wbits_next;
            hbits_reg <= hbits_next;
            len_reg   <= len_next;
            turn_reg  <= turn_next;
        end
        else if (cmd.unreg_finish)
        begin
            len_reg  <= wptr_reg;
            turn_reg <= turn_dec;
        end
    end

    // compaction pointers: read index and write index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rptr_reg <= '0;
            wptr_reg <= '0;
        end
        else if (cmd.scan_start)
        begin
            rptr_reg <= '0;
            wptr_reg <= '0;
        end
        else if (cmd.scan_write)
        begin
            rptr_reg <= rptr_reg + LEN_W'(1);
            if (rd_data_reg != id_reg)
            begin
                wptr_reg <= wptr_reg + LEN_W'(1);
            end
        end
    end

    // result register
    assign load_out = cmd.exec || cmd.unreg_finish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            out_reg.granted         <= granted;
            out_reg.status          <= status;
            out_reg.readers_held    <= rcnt_next;
            out_reg.writers_held    <= wcnt_next;
            out_reg.readers_waiting <= wait_next;
            out_reg.exclusive_held  <= excl_next;
        end
        else if (cmd.unreg_finish)
        begin
            out_reg.granted         <= 1'b0;
            out_reg.status          <= rwla_pkg::STAT_DONE;
            out_reg.readers_held    <= rcnt_reg;
            out_reg.writers_held    <= wcnt_reg;
            out_reg.readers_waiting <= wait_reg;
            out_reg.exclusive_held  <= excl_reg;
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign rsp           = out_reg;

    // status to controller
    assign sts.is_unreg  = (op_reg == rwla_pkg::OP_UNREGISTER);
    assign sts.scan_more = (rptr_reg < len_reg);
    assign sts.out_free  = !out_valid_reg || rsp_ready;

endmodule

>>> src/reader_writer_lock_arbiter_top.sv
// Reader-writer lock arbiter: top level joining controller and datapath.
// Depends on rwla_pkg, rwla_ctrl and rwla_datapath.
//
// Usage: a request item (opcode, requester_id) enters on req_valid/req_ready and
// each request gives exactly one result item on rsp_valid/rsp_ready, in order.
// Requests are handled one at a time. The accepting edge reads the turn entry of
// the order-list memory; the decision step then updates the lock state and loads
// the result into the output register once that register is free.
// An unregister compacts the order list one entry at a time, a read state then
// a write state per entry, before its result is loaded.
// The next request is taken only after the previous one has been decided; the
// registered read of the order-list memory lies ahead of each decision step.
// The output register frees the input side: a new request is taken while a result
// still waits; if the receiver stalls, the next request waits in its decision
// step until the output register is free, and req_ready stays low meanwhile.
// Reset (rst_n low, asynchronous) clears counts, flags, bitmaps, the list length
// and the turn; policy returns to "none" and reader limit to 0 (no limit).
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next edge
// and must be made while no request is in progress; the block does not enforce this.
`timescale 1ns / 1ps

module reader_writer_lock_arbiter_top #(
    parameter int MAX_REQUESTERS = rwla_pkg::DEF_MAX_REQUESTERS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             req_valid,
    output logic                             req_ready,
    input  rwla_pkg::req_item_t              req,
    output logic                             rsp_valid,
    input  logic                             rsp_ready,
    output rwla_pkg::rsp_item_t              rsp,
    input  logic                             cfg_we,
    input  logic [rwla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rwla_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rwla_pkg::ctrl_cmd_t cmd;
    rwla_pkg::ctrl_sts_t sts;

    // sequencing
    rwla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // lock state and result
    rwla_datapath #(
        .MAX_REQUESTERS (MAX_REQUESTERS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // one request in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while another is in progress");

    // an exclusive holder excludes all shared holders
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.exclusive_held &&
                        (rsp.readers_held != '0 || rsp.writers_held != '0)))
        else $error("exclusive lock reported alongside shared holders");

    // a grant always reports a plain completion
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.granted) |-> (rsp.status == rwla_pkg::STAT_DONE))
        else $error("granted result with a non-zero status");

    // a new result only follows an accepted request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> !$past(req_ready))
        else $error("result appeared without a request in progress");

endmodule
